// ===== hdl/btsp_pkg.sv =====
// ----------------------------------------------------------------------------
// btsp_pkg
// shared types, codes and limits for the ber-tlv byte stream parser
// ----------------------------------------------------------------------------
package btsp_pkg;

  // limits
  localparam int MAX_DEPTH     = 8;
  localparam int MAX_LEN_BYTES = 4;
  localparam int MAX_TAG_BYTES = 4;

  // byte patterns
  localparam logic [4:0] TAG_NUM_ESCAPE  = 5'h1f;  // low five bits all ones: tag goes on
  localparam int         CONSTRUCTED_BIT = 5;      // 0x20 of the first tag byte
  localparam int         MORE_BIT        = 7;      // 0x80: more tag bytes / long length form

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  // configuration map
  localparam int          PADDR_W         = 3;
  localparam logic [2:0]  ADDR_NEST_MODE  = 3'd0;
  localparam logic        NEST_MODE_RESET = 1'b1;

  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_VALUE     = 3'd4,
    PH_ERROR     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_TAG   = 2'd0,
    ROLE_LEN   = 2'd1,
    ROLE_VALUE = 2'd2,
    ROLE_ERR   = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LEN_LONG  = 3'd1,
    ERR_TAG_LONG  = 3'd2,
    ERR_DEPTH     = 3'd3,
    ERR_OVERRUN   = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_t;

  // control from the parser to the level stack
  typedef struct packed {
    logic consume;  // one byte taken out of every open level
    logic push;     // open a new level
    logic close;    // entity closed: pop every level that ran empty
    logic clear;    // end of buffer
  } stack_ctl_t;

  // status from the level stack
  typedef struct packed {
    logic empty;    // innermost open level has no byte left
    logic at_max;   // no room for another level
  } stack_stat_t;

  typedef struct packed {
    role_t        role;
    logic [3:0]   depth;
    logic [31:0]  tag;
    logic         tag_done;
    logic         constructed;
    logic [31:0]  len;
    logic         len_done;
    logic         entity_end;
    logic [15:0]  count;
    err_t         code;
  } result_t;

endpackage

// ===== hdl/btsp_level_stack.sv =====
// ----------------------------------------------------------------------------
// btsp_level_stack
// byte counters of the open nesting levels, with decrement and pop logic
// ----------------------------------------------------------------------------
module btsp_level_stack #(
  parameter int MAX_DEPTH = btsp_pkg::MAX_DEPTH,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  btsp_pkg::stack_ctl_t   ctl,
  input  logic [31:0]            push_len,
  output logic [DW-1:0]          depth,
  output btsp_pkg::stack_stat_t  stat,
  output logic [31:0]            rem_after,
  output logic [DW-1:0]          pop_depth
);

  logic [31:0] rem [1:MAX_DEPTH];
  logic [31:0] rem_sel;

  // innermost level and the depth left after popping levels that run out
  always_comb begin
    rem_sel   = '0;
    pop_depth = '0;
    for (int k = 1; k <= MAX_DEPTH; k++) begin
      if (k == int'(depth)) rem_sel = rem[k];
      // a level at or below the current depth survives unless this byte empties it
      if (k <= int'(depth) && rem[k] != 32'd1) pop_depth = DW'(k);
    end
  end

  assign rem_after   = rem_sel - 32'd1;
  assign stat.empty  = (depth != '0) && (rem_sel == '0);
  assign stat.at_max = (depth == DW'(MAX_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.clear) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + DW'(1);
    end else if (ctl.close) begin
      depth <= pop_depth;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= MAX_DEPTH; k++) begin
      if (ctl.push && k == int'(depth) + 1) begin
        rem[k] <= push_len;
      end else if (ctl.consume && k <= int'(depth)) begin
        rem[k] <= rem[k] - 32'd1;
      end
    end
  end

endmodule

// ===== hdl/btsp_parser.sv =====
// ----------------------------------------------------------------------------
// btsp_parser
// per-byte tag / length / value decoder with its phase and field registers
// ----------------------------------------------------------------------------
module btsp_parser #(
  parameter int MAX_DEPTH = btsp_pkg::MAX_DEPTH,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             in_byte,
  input  logic                   last_byte,
  input  logic                   nest_mode,
  input  logic [DW-1:0]          depth,
  input  btsp_pkg::stack_stat_t  stat,
  input  logic [31:0]            rem_after,
  input  logic [DW-1:0]          pop_depth,
  output btsp_pkg::stack_ctl_t   ctl,
  output logic [31:0]            push_len,
  output btsp_pkg::result_t      result
);

  btsp_pkg::phase_t phase, phase_next;
  btsp_pkg::err_t   held_code, held_code_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [2:0]  tag_count, tag_count_next;
  logic [31:0] len_shift, len_shift_next;
  logic [2:0]  len_left, len_left_next;
  logic [31:0] value_left, value_left_next;
  logic        constructed, constructed_next;
  logic [15:0] top_count, top_count_next;

  btsp_pkg::err_t  err;
  btsp_pkg::role_t role;
  btsp_pkg::err_t  code;
  logic            tdone, ldone, close, push, consume;
  logic [6:0]      len_bytes;
  logic [2:0]      len_left_dec;
  logic [31:0]     value_dec;
  logic [DW-1:0]   depth_next;

  always_comb begin
    phase_next       = phase;
    held_code_next   = held_code;
    tag_shift_next   = tag_shift;
    tag_count_next   = tag_count;
    len_shift_next   = len_shift;
    len_left_next    = len_left;
    value_left_next  = value_left;
    constructed_next = constructed;
    top_count_next   = top_count;
    err              = btsp_pkg::ERR_NONE;
    role             = btsp_pkg::ROLE_TAG;
    code             = btsp_pkg::ERR_NONE;
    tdone            = 1'b0;
    ldone            = 1'b0;
    close            = 1'b0;
    push             = 1'b0;
    consume          = 1'b0;
    len_bytes        = in_byte[6:0];
    len_left_dec     = (len_left != '0) ? len_left - 3'd1 : 3'd0;
    value_dec        = (value_left != '0) ? value_left - 32'd1 : 32'd0;
    depth_next       = depth;

    if (phase == btsp_pkg::PH_ERROR) begin
      role = btsp_pkg::ROLE_ERR;
      code = held_code;
    end else begin
      if (stat.empty) begin
        err = btsp_pkg::ERR_OVERRUN;
      end else begin
        consume = 1'b1;
        case (phase)
          btsp_pkg::PH_TAG_FIRST: begin
            role             = btsp_pkg::ROLE_TAG;
            tag_shift_next   = {24'd0, in_byte};
            tag_count_next   = 3'd1;
            constructed_next = nest_mode ? in_byte[btsp_pkg::CONSTRUCTED_BIT] : 1'b1;
            if (in_byte[4:0] == btsp_pkg::TAG_NUM_ESCAPE) begin
              phase_next = btsp_pkg::PH_TAG_MORE;
            end else begin
              tdone      = 1'b1;
              phase_next = btsp_pkg::PH_LEN_FIRST;
            end
          end
          btsp_pkg::PH_TAG_MORE: begin
            role = btsp_pkg::ROLE_TAG;
            if (tag_count >= 3'(btsp_pkg::MAX_TAG_BYTES)) begin
              err = btsp_pkg::ERR_TAG_LONG;
            end else begin
              tag_shift_next = {tag_shift[23:0], in_byte};
              tag_count_next = tag_count + 3'd1;
              if (!in_byte[btsp_pkg::MORE_BIT]) begin
                tdone      = 1'b1;
                phase_next = btsp_pkg::PH_LEN_FIRST;
              end
            end
          end
          btsp_pkg::PH_LEN_FIRST: begin
            role           = btsp_pkg::ROLE_LEN;
            len_shift_next = '0;
            if (!in_byte[btsp_pkg::MORE_BIT]) begin
              len_shift_next = {24'd0, in_byte};
              ldone          = 1'b1;
            end else if (len_bytes == '0) begin
              // long form with no length bytes: length zero
              ldone = 1'b1;
            end else if (len_bytes > 7'(btsp_pkg::MAX_LEN_BYTES)) begin
              err = btsp_pkg::ERR_LEN_LONG;
            end else begin
              len_left_next = len_bytes[2:0];
              phase_next    = btsp_pkg::PH_LEN_MORE;
            end
          end
          btsp_pkg::PH_LEN_MORE: begin
            role           = btsp_pkg::ROLE_LEN;
            len_shift_next = {len_shift[23:0], in_byte};
            len_left_next  = len_left_dec;
            if (len_left_dec == '0) ldone = 1'b1;
          end
          btsp_pkg::PH_VALUE: begin
            role            = btsp_pkg::ROLE_VALUE;
            value_left_next = value_dec;
            if (value_dec == '0) close = 1'b1;
          end
          default: begin
            role = btsp_pkg::ROLE_ERR;
          end
        endcase
      end

      // length known: open a level, enter the value or close at once, or flag an overrun or depth error
      if (ldone && err == btsp_pkg::ERR_NONE) begin
        if (depth != '0 && len_shift_next > rem_after) begin
          err = btsp_pkg::ERR_OVERRUN;
        end else if (len_shift_next == '0) begin
          close = 1'b1;
        end else if (constructed) begin
          if (stat.at_max) begin
            err = btsp_pkg::ERR_DEPTH;
          end else begin
            push       = 1'b1;
            depth_next = depth + DW'(1);
            phase_next = btsp_pkg::PH_TAG_FIRST;
          end
        end else begin
          value_left_next = len_shift_next;
          phase_next      = btsp_pkg::PH_VALUE;
        end
      end

      if (close && err == btsp_pkg::ERR_NONE) begin
        phase_next = btsp_pkg::PH_TAG_FIRST;
        depth_next = pop_depth;
        // closing back out to the top level finishes one top-level entity
        if (pop_depth == '0 && top_count != btsp_pkg::COUNT_MAX) begin
          top_count_next = top_count + 16'd1;
        end
      end

      if (err != btsp_pkg::ERR_NONE) begin
        role           = btsp_pkg::ROLE_ERR;
        code           = err;
        phase_next     = btsp_pkg::PH_ERROR;
        held_code_next = err;
        tdone          = 1'b0;
        ldone          = 1'b0;
        close          = 1'b0;
        push           = 1'b0;
      end else if (last_byte &&
                   (phase_next != btsp_pkg::PH_TAG_FIRST || depth_next != '0)) begin
        role  = btsp_pkg::ROLE_ERR;
        code  = btsp_pkg::ERR_TRUNCATED;
        tdone = 1'b0;
        ldone = 1'b0;
        close = 1'b0;
      end
    end
  end

  assign ctl.consume = step && consume;
  assign ctl.push    = step && push;
  assign ctl.close   = step && close && (err == btsp_pkg::ERR_NONE);
  assign ctl.clear   = step && last_byte;
  assign push_len    = len_shift_next;

  assign result.role        = role;
  assign result.depth       = 4'(depth);
  assign result.tag         = tag_shift_next;
  assign result.tag_done    = tdone;
  assign result.constructed = constructed_next;
  assign result.len         = len_shift_next;
  assign result.len_done    = ldone;
  assign result.entity_end  = close;
  assign result.count       = top_count_next;
  assign result.code        = code;

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase       <= btsp_pkg::PH_TAG_FIRST;
      held_code   <= btsp_pkg::ERR_NONE;
      tag_shift   <= '0;
      tag_count   <= '0;
      len_shift   <= '0;
      len_left    <= '0;
      value_left  <= '0;
      constructed <= 1'b0;
      top_count   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      held_code   <= held_code_next;
      tag_shift   <= tag_shift_next;
      tag_count   <= tag_count_next;
      len_shift   <= len_shift_next;
      len_left    <= len_left_next;
      value_left  <= value_left_next;
      constructed <= constructed_next;
      top_count   <= top_count_next;
    end
  end

endmodule

// ===== hdl/ber_tlv_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser_core
// labels each byte of a ber-tlv buffer as tag, length, value or error
// ----------------------------------------------------------------------------
// input stream (s_*): one buffer byte per item in s_tdata, s_tlast marks
// the final byte of a buffer. output stream (m_*): one result item per
// input byte; m_tuser carries the byte role, m_tdata the decoded fields.
// an item accepted at one clock edge is registered, decoded and moves into
// the output register whenever that register is free or drains; one item
// is taken every cycle while m_tready stays high. the rate is set by the
// single decode pass between the input and output registers, which carries
// the phase, field and level updates.
// a stalled receiver holds the output item; the input register still takes
// one more item, after which s_tready drops until m_tready returns.
// the apb port holds nest_mode at address 0; write it only when idle.
// reset (rst, synchronous) empties both registers, sets nest_mode to 1 and
// starts the parser expecting the first tag byte at the top level; a byte
// with s_tlast does the same for the parse state at the end of a buffer.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_core #(
  parameter int MAX_DEPTH = btsp_pkg::MAX_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] in_byte
  input  logic                         s_tlast,   // last_byte
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [3:0] nest_depth, [35:4] tag_value, [36] tag_done, [37] is_constructed,
  // [69:38] length_value, [70] length_done, [71] entity_end,
  // [87:72] entity_count, [90:88] error_code, [95:91] zero
  output logic [95:0]                  m_tdata,
  output logic [1:0]                   m_tuser,   // [1:0] byte_role
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [btsp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  // configuration register
  logic nest_mode;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // output register
  logic               out_valid;
  btsp_pkg::result_t  out_q;

  // decode stage
  logic                   advance;
  btsp_pkg::stack_ctl_t   ctl;
  btsp_pkg::stack_stat_t  stat;
  btsp_pkg::result_t      result;
  logic [31:0]            push_len;
  logic [31:0]            rem_after;
  logic [DW-1:0]          depth;
  logic [DW-1:0]          pop_depth;

  // apb: no wait states
  assign pready = 1'b1;
  assign prdata = (paddr == btsp_pkg::ADDR_NEST_MODE) ? {31'd0, nest_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_mode <= btsp_pkg::NEST_MODE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == btsp_pkg::ADDR_NEST_MODE) begin
      nest_mode <= pwdata[0];
    end
  end

  // the decoded item moves on whenever the output register is free or drains
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // nesting levels
  btsp_level_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .push_len  (push_len),
    .depth     (depth),
    .stat      (stat),
    .rem_after (rem_after),
    .pop_depth (pop_depth)
  );

  // per-byte decode
  btsp_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_byte),
    .last_byte (in_last),
    .nest_mode (nest_mode),
    .depth     (depth),
    .stat      (stat),
    .rem_after (rem_after),
    .pop_depth (pop_depth),
    .ctl       (ctl),
    .push_len  (push_len),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_q <= result;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.role;
  assign m_tdata  = {5'd0, out_q.code, out_q.count, out_q.entity_end, out_q.len_done,
                     out_q.len, out_q.constructed, out_q.tag_done, out_q.tag,
                     out_q.depth};

  // input side only stalls when both registers are full and the receiver waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a blocked output");

  // an error byte never reports completed fields
  a_err_no_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.role == btsp_pkg::ROLE_ERR) |->
      (!out_q.tag_done && !out_q.len_done && !out_q.entity_end))
    else $error("error item carries done flags");

  // error role and nonzero error code go together
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_q.role == btsp_pkg::ROLE_ERR) == (out_q.code != btsp_pkg::ERR_NONE)))
    else $error("error code does not match byte role");

  // reported depth stays inside the level stack
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.depth <= 4'(MAX_DEPTH)))
    else $error("nest depth beyond stack size");

  // an item leaves the input register only into the output register
  a_advance_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("decoded item lost");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ber-tlv byte stream parser
// ----------------------------------------------------------------------------
// bytes go in on the s_* stream and every accepted byte is run through a
// parser model kept here; each result item on the m_* stream is compared
// field by field with the oldest predicted one. directed buffers cover the
// tag and length forms, every error code and the depth limit in nest mode 1,
// then nest mode 0; random buffers (mostly well-formed, some cut short, corrupted
// or plain noise) then run under several idle mixes, with one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata  = 8'h00;
  logic                         s_tlast  = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [95:0]                  m_tdata;
  logic [1:0]                   m_tuser;
  logic                         psel     = 1'b0;
  logic                         penable  = 1'b0;
  logic                         pwrite   = 1'b0;
  logic [btsp_pkg::PADDR_W-1:0] paddr    = '0;
  logic [31:0]                  pwdata   = 32'h0;
  logic [31:0]                  prdata;
  logic                         pready;

  ber_tlv_stream_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // run bookkeeping
  int cycle_count   = 0;
  int fails         = 0;
  int bytes_sent    = 0;
  int buffers_sent  = 0;
  int results_seen  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  // parser model state
  logic              cfg_nest;
  btsp_pkg::phase_t  ph;
  logic [31:0]       tag_acc;
  int unsigned       tag_cnt;
  logic [31:0]       len_acc;
  int unsigned       len_left;
  logic [31:0]       lvl_left [0:btsp_pkg::MAX_DEPTH];
  int unsigned       depth_now;
  logic              cons_flag;
  logic [15:0]       top_cnt;
  logic [31:0]       val_left;
  btsp_pkg::err_t    held;

  btsp_pkg::result_t pending_results [$];
  btsp_pkg::result_t oldest;

  // buffer under construction and scratch queues
  logic [7:0]  frame [$];
  logic [7:0]  piece [$];
  logic [7:0]  inner [$];

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_parse_state();
    int k;
    ph        = btsp_pkg::PH_TAG_FIRST;
    tag_acc   = 32'h0;
    tag_cnt   = 0;
    len_acc   = 32'h0;
    len_left  = 0;
    for (k = 0; k <= btsp_pkg::MAX_DEPTH; k++) lvl_left[k] = 32'h0;
    depth_now = 0;
    cons_flag = 1'b0;
    top_cnt   = 16'h0;
    val_left  = 32'h0;
    held      = btsp_pkg::ERR_NONE;
  endfunction

  // one byte through the parser: updates the model and returns its result
  function automatic btsp_pkg::result_t decode_byte(input logic [7:0] b, input logic last);
    btsp_pkg::result_t r;
    int unsigned       d;
    int unsigned       k;
    btsp_pkg::err_t    err;
    logic              tdone, ldone, eend, closing;
    logic [31:0]       len;
    d = depth_now;
    if (d > btsp_pkg::MAX_DEPTH) d = btsp_pkg::MAX_DEPTH;
    err = btsp_pkg::ERR_NONE;
    tdone = 1'b0;
    ldone = 1'b0;
    eend = 1'b0;
    closing = 1'b0;
    r.role = btsp_pkg::ROLE_TAG;
    r.code = btsp_pkg::ERR_NONE;
    if (ph == btsp_pkg::PH_ERROR) begin
      r.role = btsp_pkg::ROLE_ERR;
      r.code = held;
    end else begin
      if (d >= 1 && lvl_left[d] == 0) begin
        err = btsp_pkg::ERR_OVERRUN;  // header byte past the end of the parent
      end else begin
        for (k = 1; k <= d; k++) lvl_left[k] = lvl_left[k] - 1;
        case (ph)
          btsp_pkg::PH_TAG_FIRST: begin
            r.role = btsp_pkg::ROLE_TAG;
            tag_acc = {24'h0, b};
            tag_cnt = 1;
            cons_flag = cfg_nest ? b[btsp_pkg::CONSTRUCTED_BIT] : 1'b1;
            if (b[4:0] == btsp_pkg::TAG_NUM_ESCAPE) begin
              ph = btsp_pkg::PH_TAG_MORE;
            end else begin
              tdone = 1'b1;
              ph = btsp_pkg::PH_LEN_FIRST;
            end
          end
          btsp_pkg::PH_TAG_MORE: begin
            r.role = btsp_pkg::ROLE_TAG;
            if (tag_cnt >= btsp_pkg::MAX_TAG_BYTES) begin
              err = btsp_pkg::ERR_TAG_LONG;
            end else begin
              tag_acc = {tag_acc[23:0], b};
              tag_cnt++;
              if (!b[btsp_pkg::MORE_BIT]) begin
                tdone = 1'b1;
                ph = btsp_pkg::PH_LEN_FIRST;
              end
            end
          end
          btsp_pkg::PH_LEN_FIRST: begin
            r.role = btsp_pkg::ROLE_LEN;
            len_acc = 32'h0;
            if (!b[btsp_pkg::MORE_BIT]) begin
              len_acc = {24'h0, b};
              ldone = 1'b1;
            end else if (b[6:0] == 7'h0) begin
              ldone = 1'b1;  // long form with no length bytes means zero
            end else if (b[6:0] > btsp_pkg::MAX_LEN_BYTES) begin
              err = btsp_pkg::ERR_LEN_LONG;
            end else begin
              len_left = int'(b[6:0]);
              ph = btsp_pkg::PH_LEN_MORE;
            end
          end
          btsp_pkg::PH_LEN_MORE: begin
            r.role = btsp_pkg::ROLE_LEN;
            len_acc = {len_acc[23:0], b};
            if (len_left > 0) len_left--;
            if (len_left == 0) ldone = 1'b1;
          end
          default: begin
            r.role = btsp_pkg::ROLE_VALUE;
            if (val_left > 0) val_left = val_left - 1;
            if (val_left == 0) closing = 1'b1;
          end
        endcase
      end

      if (ldone && err == btsp_pkg::ERR_NONE) begin
        len = len_acc;
        if (d >= 1 && len > lvl_left[d]) begin
          err = btsp_pkg::ERR_OVERRUN;
        end else if (len == 0) begin
          closing = 1'b1;
        end else if (cons_flag) begin
          if (d >= btsp_pkg::MAX_DEPTH) begin
            err = btsp_pkg::ERR_DEPTH;
          end else begin
            depth_now = d + 1;
            lvl_left[d + 1] = len;
            ph = btsp_pkg::PH_TAG_FIRST;
          end
        end else begin
          val_left = len;
          ph = btsp_pkg::PH_VALUE;
        end
      end

      if (closing && err == btsp_pkg::ERR_NONE) begin
        ph = btsp_pkg::PH_TAG_FIRST;
        eend = 1'b1;
        if (d == 0 && top_cnt != btsp_pkg::COUNT_MAX) top_cnt++;
        // pop every level that ran empty with this byte
        while (depth_now > 0 && lvl_left[depth_now] == 0) begin
          depth_now--;
          if (depth_now == 0 && top_cnt != btsp_pkg::COUNT_MAX) top_cnt++;
        end
      end

      if (err != btsp_pkg::ERR_NONE) begin
        r.role = btsp_pkg::ROLE_ERR;
        r.code = err;
        ph = btsp_pkg::PH_ERROR;
        held = err;
        tdone = 1'b0;
        ldone = 1'b0;
        eend = 1'b0;
      end else if (last && (ph != btsp_pkg::PH_TAG_FIRST || depth_now != 0)) begin
        r.role = btsp_pkg::ROLE_ERR;  // buffer ends inside an entity
        r.code = btsp_pkg::ERR_TRUNCATED;
        tdone = 1'b0;
        ldone = 1'b0;
        eend = 1'b0;
      end
    end

    r.depth       = d[3:0];
    r.tag         = tag_acc;
    r.tag_done    = tdone;
    r.constructed = cons_flag;
    r.len         = len_acc;
    r.len_done    = ldone;
    r.entity_end  = eend;
    r.count       = top_cnt;
    if (last) clear_parse_state();
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors

  // predict on every accepted byte
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pending_results.push_back(decode_byte(s_tdata, s_tlast));
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no byte pending, expected none actual %0h/%0h",
                 $time, m_tuser, m_tdata);
        fails++;
      end else begin
        oldest = pending_results.pop_front();
        results_seen++;
        check_field("byte_role",      32'(oldest.role),        32'(m_tuser));
        check_field("nest_depth",     32'(oldest.depth),       32'(m_tdata[3:0]));
        check_field("tag_value",      oldest.tag,              m_tdata[35:4]);
        check_field("tag_done",       32'(oldest.tag_done),    32'(m_tdata[36]));
        check_field("is_constructed", 32'(oldest.constructed), 32'(m_tdata[37]));
        check_field("length_value",   oldest.len,              m_tdata[69:38]);
        check_field("length_done",    32'(oldest.len_done),    32'(m_tdata[70]));
        check_field("entity_end",     32'(oldest.entity_end),  32'(m_tdata[71]));
        check_field("entity_count",   32'(oldest.count),       32'(m_tdata[87:72]));
        check_field("error_code",     32'(oldest.code),        32'(m_tdata[90:88]));
        check_field("tdata pad",      32'h0,                   32'(m_tdata[95:91]));
      end
    end
  end

  // receiver: random idling, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // send the first n bytes of the frame, the n-th marked last
  task automatic send_frame(input int n);
    int i;
    for (i = 0; i < n; i++) send_item(frame[i], i == n - 1);
    buffers_sent++;
  endtask

  // stop sending until every predicted result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [btsp_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == btsp_pkg::ADDR_NEST_MODE) cfg_nest = data[0];
  endtask

  // ---------------------------------------------------------------- buffer builders

  task automatic put_tag(input logic cons);
    logic [31:0] rw;
    int          extra;
    int          i;
    rw = $urandom;
    if ($urandom_range(3) == 0) begin
      // multi-byte tag, two to four bytes in all
      piece.push_back({rw[7:6], cons, btsp_pkg::TAG_NUM_ESCAPE});
      extra = $urandom_range(3, 1);
      for (i = 1; i < extra; i++) begin
        rw = $urandom;
        piece.push_back({1'b1, rw[6:0]});
      end
      rw = $urandom;
      piece.push_back({1'b0, rw[6:0]});
    end else begin
      rw[4:0] = 5'($urandom_range(30));
      piece.push_back({rw[7:6], cons, rw[4:0]});
    end
  endtask

  task automatic put_len(input logic [31:0] len);
    int          n;
    int          need;
    int          i;
    logic [31:0] sh;
    if (len < 128 && $urandom_range(3) != 0) begin
      piece.push_back(len[7:0]);
    end else if (len == 0 && $urandom_range(1) == 1) begin
      piece.push_back(8'h80);
    end else begin
      need = (len < 256) ? 1 : ((len < 65536) ? 2 : 3);
      n = $urandom_range(btsp_pkg::MAX_LEN_BYTES, need);
      sh = n;
      piece.push_back({1'b1, sh[6:0]});
      for (i = n - 1; i >= 0; i--) begin
        sh = len >> (8 * i);
        piece.push_back(sh[7:0]);
      end
    end
  endtask

  task automatic flush_piece();
    while (piece.size() != 0) frame.push_back(piece.pop_front());
  endtask

  // one entity with no children: a primitive with a value, or an empty nested tag
  task automatic put_leaf();
    logic [31:0] rw;
    int          n;
    rw = $urandom;
    piece.delete();
    if (cfg_nest && $urandom_range(2) != 0) begin
      put_tag(1'b0);
      n = ($urandom_range(99) < 4) ? $urandom_range(150, 128) : $urandom_range(6);
      put_len(32'(n));
      repeat (n) begin
        rw = $urandom;
        piece.push_back(rw[7:0]);
      end
    end else begin
      put_tag(cfg_nest ? 1'b1 : rw[5]);
      put_len(32'h0);
    end
    flush_piece();
  endtask

  // wrap everything from index at_mark on into one nested entity
  task automatic close_level(input int at_mark);
    logic [31:0] rw;
    rw = $urandom;
    piece.delete();
    inner.delete();
    put_tag(cfg_nest ? 1'b1 : rw[5]);
    while (frame.size() > at_mark) inner.push_front(frame.pop_back());
    put_len(32'(inner.size()));
    while (inner.size() != 0) piece.push_back(inner.pop_front());
    flush_piece();
  endtask

  // well-formed buffer of random shape under the current nest mode
  task automatic make_buffer();
    int marks [0:btsp_pkg::MAX_DEPTH];
    int d;
    int r;
    frame.delete();
    d = 0;
    marks[0] = 0;
    repeat ($urandom_range(10, 1)) begin
      r = $urandom_range(99);
      if (d > 0 && r < 25) begin
        close_level(marks[d]);
        d--;
      end else if (d < btsp_pkg::MAX_DEPTH && r < 55) begin
        d++;
        marks[d] = frame.size();
      end else begin
        put_leaf();
      end
    end
    while (d > 0) begin
      close_level(marks[d]);
      d--;
    end
    if (frame.size() == 0) put_leaf();
  endtask

  // ---------------------------------------------------------------- tests

  // short and multi-byte tags, short form and long form lengths (n of 0, 2 and 4)
  task automatic test_tag_and_length_forms();
    frame = '{8'h01, 8'h02, 8'h00, 8'hff};
    send_frame(frame.size());
    frame = '{8'h9f, 8'h81, 8'h01, 8'h80};
    send_frame(frame.size());
    frame = '{8'h20, 8'h82, 8'h00, 8'h02, 8'h04, 8'h00};
    send_frame(frame.size());
    frame = '{8'hc1, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7f};
    send_frame(frame.size());
  endtask

  task automatic test_error_codes();
    // too many length bytes, then a byte inside the latched error
    frame = '{8'h01, 8'h85, 8'h33};
    send_frame(frame.size());
    // five-byte tag
    frame = '{8'h1f, 8'h81, 8'h82, 8'h83, 8'h84};
    send_frame(frame.size());
    // buffer ends in the middle of a value
    frame = '{8'h02, 8'h03, 8'h11};
    send_frame(frame.size());
    // tag byte past the end of its parent
    frame = '{8'h20, 8'h01, 8'h1f, 8'h01};
    send_frame(frame.size());
    // child length larger than what is left in the parent
    frame = '{8'h20, 8'h02, 8'h01, 8'h05};
    send_frame(frame.size());
  endtask

  // nesting to the full depth, then one level more
  task automatic test_depth_limit();
    int i;
    frame = '{8'h01, 8'h00};
    for (i = 0; i < btsp_pkg::MAX_DEPTH; i++) close_level(0);
    send_frame(frame.size());
    frame = '{8'h20, 8'h01, 8'h00};
    for (i = 0; i < btsp_pkg::MAX_DEPTH; i++) close_level(0);
    send_frame(frame.size());
  endtask

  // with nest_mode 0 a primitive tag's value is parsed as children too
  task automatic test_nest_every_tag();
    drain_results();
    apb_write(btsp_pkg::ADDR_NEST_MODE, 32'h0);
    frame = '{8'h01, 8'h02, 8'h05, 8'h00};
    send_frame(frame.size());
    frame = '{8'h41, 8'h81, 8'h02, 8'h1e, 8'h00};
    send_frame(frame.size());
  endtask

  task automatic run_random_stream(input int snd_pct, input int rcv_pct,
                                   input logic mode, input int n_items);
    logic [31:0] rw;
    int          goal;
    int          kind;
    drain_results();
    apb_write(btsp_pkg::ADDR_NEST_MODE, {31'h0, mode});
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      make_buffer();
      kind = $urandom_range(99);
      if (kind < 10) begin
        send_frame($urandom_range(frame.size(), 1));  // cut short
      end else if (kind < 18) begin
        rw = $urandom;
        frame[$urandom_range(frame.size() - 1)] = rw[7:0];  // one byte corrupted
        send_frame(frame.size());
      end else if (kind < 25) begin
        frame.delete();
        repeat ($urandom_range(10, 1)) begin
          rw = $urandom;
          frame.push_back(rw[7:0]);
        end
        send_frame(frame.size());
      end else begin
        send_frame(frame.size());
      end
    end
  endtask

  // receiver holds off while bytes keep coming, so the input side stalls
  task automatic test_output_backpressure();
    int goal;
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left <= 300;
    goal = bytes_sent + 60;
    while (bytes_sent < goal) begin
      make_buffer();
      send_frame(frame.size());
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg_nest = btsp_pkg::NEST_MODE_RESET;
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tag_and_length_forms();
    test_error_codes();
    test_depth_limit();
    test_nest_every_tag();
    run_random_stream(9, 77, 1'b1, 140);
    run_random_stream(77, 9, 1'b0, 140);
    run_random_stream(0, 0, 1'b1, 140);
    test_output_backpressure();
    drain_results();
    $display("tb: %0d bytes in %0d buffers, %0d results checked, %0d mismatches",
             bytes_sent, buffers_sent, results_seen, fails);
    $display("tb: tag and length forms, all error codes, depth limit, both nest modes,");
    $display("tb: idle mixes on both sides and a long output stall");
    if (fails == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
